// ----- design/bfr_pkg.sv -----
// Package for the brightness fade ramp: widths, blend control codes and the
// controller state type. No dependencies; imported by every module of the block.
`default_nettype none

package bfr_pkg;

    localparam int LVL_W  = 8;
    localparam int PROD_W = 2 * LVL_W;
    localparam int MASK_W = 6;

    localparam int MUL_STEPS = LVL_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Blend control base codes, ORed with the layer mask.
    localparam logic [LVL_W-1:0] CTL_BRIGHT = 8'h80;
    localparam logic [LVL_W-1:0] CTL_DARK   = 8'hC0;

    // A start level above this value means "start from the current target".
    localparam logic [LVL_W-1:0] START_LIMIT = 8'h10;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ----- design/bfr_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on bfr_pkg for the operand and product widths.
`default_nettype none

module bfr_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bfr_pkg::LVL_W-1:0]  i_mcand,
    input  wire logic [bfr_pkg::LVL_W-1:0]  i_mplier,
    output logic                            o_done,
    output logic [bfr_pkg::PROD_W-1:0]      o_product
);
    import bfr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [LVL_W-1:0]     r_mcand;
    logic [LVL_W-1:0]     r_hi;
    logic [LVL_W-1:0]     r_lo;
    logic [LVL_W:0]       n_sum;

    // Add the multiplicand into the high half when the current bit is set.
    always_comb begin
        n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            {r_hi, r_lo} <= {n_sum, r_lo[LVL_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

`default_nettype wire

// ----- design/bfr_div.sv -----
// Restoring divider, one quotient bit per cycle, for an unsigned product by
// an unsigned nonzero length. Depends on bfr_pkg for widths.
`default_nettype none

module bfr_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bfr_pkg::PROD_W-1:0] i_dividend,
    input  wire logic [bfr_pkg::LVL_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [bfr_pkg::PROD_W-1:0]      o_quotient
);
    import bfr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [LVL_W-1:0]     r_divisor;
    logic [LVL_W-1:0]     r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [LVL_W:0]       n_trial;
    logic [LVL_W:0]       n_diff;
    logic                 n_bit;

    // Bring down the next dividend bit and try a subtraction.
    always_comb begin
        n_trial = {r_rem, r_quo[PROD_W-1]};
        n_diff  = n_trial - {1'b0, r_divisor};
        n_bit   = (n_trial >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_bit ? n_diff[LVL_W-1:0] : n_trial[LVL_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], n_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- design/brightness_fade_ramp.sv -----
// Top level of the brightness fade ramp: fade state, sequencing and output register.
// Depends on bfr_pkg, bfr_mul and bfr_div.
`default_nettype none

// The block takes one transaction per input item on the i_in_valid / o_in_ready
// channel. A start command (i_command high) loads mode, layer mask, start level,
// target level and length in frames and gives no result.
// A frame tick (i_command low) while a fade is active gives one result on the
// o_out_valid / i_out_ready channel: the blend control byte, the interpolated
// level and a flag that marks the last frame. A tick while idle is taken and
// gives nothing.
// A tick with an active fade runs through a bit-serial multiplier and then a
// bit-serial restoring divider, and the quotient is stored in the output
// register; the block accepts no next item until that result is stored.
// The output register frees the datapath as soon as the result is stored, so a
// waiting result does not hold up the next item.
// If the receiver stalls while a second result is ready, the block holds that
// result in the datapath and keeps o_in_ready low until the register empties.
// Synchronous reset returns the block to idle with all fade state zero and no
// result pending.
module brightness_fade_ramp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_command,
    input  wire logic                       i_brighten_mode,
    input  wire logic [bfr_pkg::MASK_W-1:0] i_layer_mask,
    input  wire logic [bfr_pkg::LVL_W-1:0]  i_start_level,
    input  wire logic [bfr_pkg::LVL_W-1:0]  i_target_level,
    input  wire logic [bfr_pkg::LVL_W-1:0]  i_frame_count,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [bfr_pkg::LVL_W-1:0]       o_blend_ctrl,
    output logic [bfr_pkg::LVL_W-1:0]       o_blend_level,
    output logic                            o_fade_done
);
    import bfr_pkg::*;

    // Fade state.
    logic              r_mode;
    logic [MASK_W-1:0] r_layers;
    logic [LVL_W-1:0]  r_from;
    logic [LVL_W-1:0]  r_to;
    logic [LVL_W-1:0]  r_length;
    logic [LVL_W-1:0]  r_left;

    // Per-tick working values, held while the serial units run.
    t_state            r_state;
    logic              r_neg;
    logic              r_last;
    logic [LVL_W-1:0]  r_len_work;

    // Output register.
    logic              r_out_valid;
    logic [LVL_W-1:0]  r_out_control;
    logic [LVL_W-1:0]  r_out_level;
    logic              r_out_done;

    logic              in_fire;
    logic              tick_go;
    logic [LVL_W-1:0]  n_left;
    logic [LVL_W-1:0]  n_mag;
    logic              mul_done;
    logic [PROD_W-1:0] mul_product;
    logic              div_done;
    logic [PROD_W-1:0] div_quotient;
    logic              out_free;
    logic              out_load;
    logic [LVL_W-1:0]  n_out_control;
    logic [LVL_W-1:0]  n_out_level;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign tick_go    = in_fire && !i_command && (r_length != '0);
    assign n_left     = r_left - 1'b1;
    assign n_mag      = (r_from >= r_to) ? (r_from - r_to) : (r_to - r_from);

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = out_free && ((r_state == S_DIV && div_done) || r_state == S_WAIT);

    // The quotient is never above the level difference, so its low byte is exact,
    // and the result stays between the start and target levels.
    always_comb begin
        n_out_control = (r_mode ? CTL_BRIGHT : CTL_DARK) | {{(LVL_W-MASK_W){1'b0}}, r_layers};
        n_out_level   = r_neg ? (r_to - div_quotient[LVL_W-1:0])
                              : (r_to + div_quotient[LVL_W-1:0]);
    end

    bfr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (tick_go),
        .i_mcand   (n_mag),
        .i_mplier  (n_left),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    bfr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_MUL && mul_done),
        .i_dividend (mul_product),
        .i_divisor  (r_len_work),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Sequencer and fade state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= 1'b0;
            r_layers <= '0;
            r_from   <= '0;
            r_to     <= '0;
            r_length <= '0;
            r_left   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && i_command) begin
                        r_mode   <= i_brighten_mode;
                        r_layers <= i_layer_mask;
                        r_from   <= (i_start_level > START_LIMIT) ? r_to : i_start_level;
                        r_to     <= i_target_level;
                        r_length <= i_frame_count;
                        r_left   <= i_frame_count;
                    end else if (tick_go) begin
                        r_left <= n_left;
                        // The last frame ends the fade.
                        if (n_left == '0) begin
                            r_length <= '0;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= out_free ? S_IDLE : S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Working values captured when a tick starts.
    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_neg      <= (r_from < r_to);
            r_last     <= (n_left == '0);
            r_len_work <= r_length;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_control <= n_out_control;
            r_out_level   <= n_out_level;
            r_out_done    <= r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_blend_ctrl  = r_out_control;
    assign o_blend_level = r_out_level;
    assign o_fade_done   = r_out_done;

    // A tick on an active fade always starts the multiplier.
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_go |=> (r_state == S_MUL))
        else $error("active tick did not start the serial multiply");

    // The divider only finishes while the sequencer waits for it.
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside of the divide step");

    // The last frame of a fade leaves no fade active.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |-> (r_length == '0))
        else $error("final frame left the fade active");

    // The interpolated level stays between the start and target levels.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> ((n_out_level >= r_from && n_out_level <= r_to) ||
                      (n_out_level >= r_to && n_out_level <= r_from)))
        else $error("interpolated level outside the fade range");

endmodule

`default_nettype wire
